// ===== rtl/arp_pkg.sv =====
`default_nettype none
package arp_pkg;

  localparam logic       OPN_RESOLVE    = 1'b0;
  localparam logic       OPN_PACKET     = 1'b1;
  localparam logic [15:0] HW_ETHERNET   = 16'h0001;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [7:0]  HW_ADDR_LEN   = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
  localparam logic [15:0] ARP_OP_NONE    = 16'd0;
  localparam logic [47:0] MAC_BCAST     = 48'hFFFF_FFFF_FFFF;
  localparam int          MCAST_BIT     = 40;

  localparam logic [1:0]  CFG_OWN_IP    = 2'd0;
  localparam logic [1:0]  CFG_OWN_MAC   = 2'd1;
  localparam logic [1:0]  CFG_MAX_LIFE  = 2'd2;
  localparam logic [15:0] MAX_LIFE_RST  = 16'd60;

  typedef enum logic [2:0] {
    K_HIT     = 3'd0,
    K_REQUEST = 3'd1,
    K_REPLY   = 3'd2,
    K_LEARNED = 3'd3,
    K_DROPPED = 3'd4,
    K_INVALID = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_REQUESTED = 2'd1,
    ST_VALID     = 2'd2
  } entry_st_t;

  typedef enum logic [2:0] {
    CMD_RESOLVE = 3'd0,
    CMD_REPLY   = 3'd1,
    CMD_LEARN   = 3'd2,
    CMD_DROP    = 3'd3,
    CMD_INVALID = 3'd4
  } cmd_t;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_EVAL = 1'b1
  } back_state_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_sec;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_op;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] frame_src_mac;
  } arp_in_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] resolved_mac;
    logic [47:0] frame_dest_mac;
    logic [15:0] arp_op_out;
    logic [47:0] target_mac_out;
    logic [31:0] sender_ip_out;
    logic [31:0] target_ip_out;
    logic        release_waiting;
  } arp_out_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  slot_octet;
    logic [31:0] now_sec;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] frame_src_mac;
  } queue_item_t;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [15:0] max_life;
  } arp_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/arp_cache_and_responder.sv =====
// ARP cache and responder, direct-mapped, one result per request.
// Input channel in_valid/in_ready/in_data carries a resolve or a received
// ARP packet; result channel out_valid/out_ready/out_data carries one result
// per request, in order. Configuration writes use cfg_we/cfg_index/cfg_wdata
// and take effect at the next edge; write them only while the block is idle.
// Requests are classified on entry and held in a two-deep queue, so
// in_ready stays high until two requests wait behind the table stage.
// The table stage first reads the entry (registered memory read), then
// evaluates it, updates the entry and loads the output register. It pops the
// next request from the queue only after that load, so it works on one
// request at a time while the queue goes on accepting requests until full.
// While out_ready is low the result is held, the table stage stops after
// one further request and the queue fills, then in_ready drops.
// Synchronous reset marks every entry empty at once, sets own_ip to zero
// and max_life to 60; there is no clearing pass.
`default_nettype none
module arp_cache_and_responder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arp_pkg::arp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output arp_pkg::arp_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_wdata
);
  import arp_pkg::*;

  logic [31:0]  own_ip_r;
  logic [15:0]  max_life_r;
  arp_cfg_t     cfg;
  queue_item_t  front_item, head_item;
  logic         q_full, q_push, q_pop, q_valid;

  assign cfg.own_ip   = own_ip_r;
  assign cfg.max_life = max_life_r;
  assign in_ready     = !q_full;
  assign q_push       = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r   <= 32'd0;
      max_life_r <= MAX_LIFE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:   own_ip_r   <= cfg_wdata[31:0];
        CFG_OWN_MAC:  ;
        CFG_MAX_LIFE: max_life_r <= cfg_wdata[15:0];
        default:      ;
      endcase
    end
  end

  arp_front u_front (
    .in_data (in_data),
    .cfg     (cfg),
    .item    (front_item)
  );

  arp_req_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_item  (head_item),
    .head_valid (q_valid)
  );

  arp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (head_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

// ===== rtl/arp_front.sv =====
`default_nettype none
module arp_front (
  input  arp_pkg::arp_in_t     in_data,
  input  arp_pkg::arp_cfg_t    cfg,
  output arp_pkg::queue_item_t item
);
  import arp_pkg::*;

  logic header_ok;

  assign header_ok = (in_data.hw_type == HW_ETHERNET) && (in_data.proto_type == PROTO_IPV4) &&
                     (in_data.hw_len == HW_ADDR_LEN) && (in_data.proto_len == PROTO_ADDR_LEN);

  always_comb begin
    item.now_sec       = in_data.now_sec;
    item.sender_mac    = in_data.sender_mac;
    item.sender_ip     = in_data.sender_ip;
    item.target_ip     = in_data.target_ip;
    item.frame_src_mac = in_data.frame_src_mac;
    item.slot_octet    = in_data.target_ip[7:0];
    item.cmd           = CMD_INVALID;
    priority if (in_data.operation == OPN_RESOLVE) begin
      item.cmd = CMD_RESOLVE;
    end else if (!header_ok) begin
      item.cmd = CMD_INVALID;
    end else if (in_data.arp_op == ARP_OP_REQUEST) begin
      item.cmd = (in_data.target_ip == cfg.own_ip) ? CMD_REPLY : CMD_DROP;
    end else if (in_data.arp_op == ARP_OP_REPLY) begin
      item.slot_octet = in_data.sender_ip[7:0];
      if ((in_data.target_ip != cfg.own_ip) || in_data.sender_mac[MCAST_BIT]) begin
        item.cmd = CMD_INVALID;
      end else begin
        item.cmd = CMD_LEARN;
      end
    end else begin
      item.cmd = CMD_INVALID;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/arp_queue.sv =====
`default_nettype none
module arp_req_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  arp_pkg::queue_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output arp_pkg::queue_item_t head_item,
  output logic                 head_valid
);
  import arp_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  queue_item_t slot_r [2];
  logic [1:0]  count_r, count_nxt;
  logic        wr_ptr_r, rd_ptr_r;

  assign full       = (count_r == QDEPTH);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule
`default_nettype wire

// ===== rtl/arp_back.sv =====
`default_nettype none
module arp_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  arp_pkg::queue_item_t q_item,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  arp_pkg::arp_cfg_t    cfg,
  output arp_pkg::arp_out_t    out_data,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import arp_pkg::*;

  localparam int         IDX_W    = $clog2(TABLE_ENTRIES);
  localparam logic [7:0] IDX_MASK = 8'(TABLE_ENTRIES - 1);
  localparam logic [8:0] DEPTH    = 9'(TABLE_ENTRIES);

  back_state_t      state_r, state_nxt;
  queue_item_t      item_r;
  logic [IDX_W-1:0] idx_r, head_idx;
  logic [7:0]       head_masked;
  logic [47:0]      mem_mac  [TABLE_ENTRIES];
  logic [31:0]      mem_time [TABLE_ENTRIES];
  logic [47:0]      rd_mac_r;
  logic [31:0]      rd_time_r;
  entry_st_t        status_r [TABLE_ENTRIES];
  entry_st_t        cur_status, status_wdata;
  logic             status_we, mem_we, load;
  logic [32:0]      limit;
  logic             expired;
  logic             out_valid_r;
  arp_out_t         out_data_r, out_data_nxt;

  assign head_masked = q_item.slot_octet & IDX_MASK;
  assign head_idx    = ({1'b0, head_masked} < DEPTH) ? head_masked[IDX_W-1:0] : '0;
  assign cur_status  = status_r[idx_r];
  assign limit       = {1'b0, rd_time_r} + {17'd0, cfg.max_life};
  assign expired     = ({1'b0, item_r.now_sec} > limit);
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_EVAL;
        end
      end
      BK_EVAL: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_data_nxt      = '0;
    out_data_nxt.kind = K_INVALID;
    status_wdata      = ST_REQUESTED;
    status_we         = 1'b0;
    mem_we            = 1'b0;
    unique case (item_r.cmd)
      CMD_RESOLVE: begin
        if ((cur_status == ST_VALID) && !expired) begin
          out_data_nxt.kind         = K_HIT;
          out_data_nxt.resolved_mac = rd_mac_r;
        end else begin
          status_we                   = load;
          status_wdata                = ST_REQUESTED;
          out_data_nxt.kind           = K_REQUEST;
          out_data_nxt.frame_dest_mac = MAC_BCAST;
          out_data_nxt.arp_op_out     = ARP_OP_REQUEST;
          out_data_nxt.sender_ip_out  = cfg.own_ip;
          out_data_nxt.target_ip_out  = item_r.target_ip;
        end
      end
      CMD_REPLY: begin
        out_data_nxt.kind           = K_REPLY;
        out_data_nxt.frame_dest_mac = item_r.frame_src_mac;
        out_data_nxt.arp_op_out     = ARP_OP_REPLY;
        out_data_nxt.target_mac_out = item_r.frame_src_mac;
        out_data_nxt.sender_ip_out  = cfg.own_ip;
        out_data_nxt.target_ip_out  = item_r.sender_ip;
      end
      CMD_LEARN: begin
        status_we                    = load;
        mem_we                       = load;
        status_wdata                 = ST_VALID;
        out_data_nxt.kind            = K_LEARNED;
        out_data_nxt.release_waiting = (cur_status == ST_REQUESTED);
      end
      CMD_DROP: begin
        out_data_nxt.kind = K_DROPPED;
      end
      default: begin
        out_data_nxt.kind       = K_INVALID;
        out_data_nxt.arp_op_out = ARP_OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) status_r[i] <= ST_EMPTY;
    end else if (status_we) begin
      status_r[idx_r] <= status_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r    <= q_item;
      idx_r     <= head_idx;
      rd_mac_r  <= mem_mac[head_idx];
      rd_time_r <= mem_time[head_idx];
    end
    if (mem_we) begin
      mem_mac[idx_r]  <= item_r.sender_mac;
      mem_time[idx_r] <= item_r.now_sec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import arp_pkg::*;

  localparam int SLOTS = 16;
  localparam int RANDOM_PER_PHASE = 105;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  arp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  arp_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_OWN_IP;
  logic [47:0] cfg_wdata = '0;

  logic [31:0] station_ip;
  logic [47:0] station_mac;
  logic [15:0] life_limit;
  entry_st_t   slot_state [SLOTS];
  logic [47:0] slot_mac [SLOTS];
  logic [31:0] slot_learned_at [SLOTS];

  arp_out_t    pending_results [$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  int          ready_hold = 0;
  int          ready_roll;

  always #4 clk = ~clk;

  arp_cache_and_responder #(.TABLE_ENTRIES(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int unsigned cache_slot(input logic [31:0] ip);
    return int'(ip[7:0]) & (SLOTS - 1);
  endfunction

  function automatic arp_out_t predict_arp_result(input arp_in_t req);
    arp_out_t    res;
    int unsigned slot;
    logic [32:0] deadline;
    bit          usable;
    res = '0;
    usable = 1'b0;
    if (req.operation == OPN_RESOLVE) begin
      slot = cache_slot(req.target_ip);
      if (slot_state[slot] != ST_EMPTY && slot_state[slot] != ST_REQUESTED) begin
        deadline = {1'b0, slot_learned_at[slot]} + {17'b0, life_limit};
        usable = ({1'b0, req.now_sec} <= deadline);
      end
      if (usable) begin
        res.kind = K_HIT;
        res.resolved_mac = slot_mac[slot];
      end else begin
        slot_state[slot] = ST_REQUESTED;
        res.kind = K_REQUEST;
        res.frame_dest_mac = MAC_BCAST;
        res.arp_op_out = ARP_OP_REQUEST;
        res.sender_ip_out = station_ip;
        res.target_ip_out = req.target_ip;
      end
    end else if (req.hw_type != HW_ETHERNET || req.proto_type != PROTO_IPV4 ||
                 req.hw_len != HW_ADDR_LEN || req.proto_len != PROTO_ADDR_LEN) begin
      res.kind = K_INVALID;
    end else if (req.arp_op == ARP_OP_REQUEST) begin
      if (req.target_ip != station_ip) begin
        res.kind = K_DROPPED;
      end else begin
        res.kind = K_REPLY;
        res.frame_dest_mac = req.frame_src_mac;
        res.arp_op_out = ARP_OP_REPLY;
        res.target_mac_out = req.frame_src_mac;
        res.sender_ip_out = station_ip;
        res.target_ip_out = req.sender_ip;
      end
    end else if (req.arp_op == ARP_OP_REPLY) begin
      slot = cache_slot(req.sender_ip);
      if (req.target_ip != station_ip || req.sender_mac[MCAST_BIT]) begin
        res.kind = K_INVALID;
      end else begin
        res.kind = K_LEARNED;
        res.release_waiting = (slot_state[slot] == ST_REQUESTED);
        slot_mac[slot] = req.sender_mac;
        slot_learned_at[slot] = req.now_sec;
        slot_state[slot] = ST_VALID;
      end
    end else begin
      res.kind = K_INVALID;
    end
    return res;
  endfunction

  function automatic logic [47:0] random_mac();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic arp_in_t make_packet(input logic [15:0] op, input logic [47:0] smac,
                                          input logic [31:0] sip, input logic [31:0] tip,
                                          input logic [47:0] fsrc, input logic [31:0] now);
    arp_in_t req;
    req.operation = OPN_PACKET;
    req.now_sec = now;
    req.hw_type = HW_ETHERNET;
    req.proto_type = PROTO_IPV4;
    req.hw_len = HW_ADDR_LEN;
    req.proto_len = PROTO_ADDR_LEN;
    req.arp_op = op;
    req.sender_mac = smac;
    req.sender_ip = sip;
    req.target_ip = tip;
    req.frame_src_mac = fsrc;
    return req;
  endfunction

  function automatic arp_in_t make_resolve(input logic [31:0] tip, input logic [31:0] now);
    arp_in_t req;
    req = make_packet(16'($urandom()), random_mac(), $urandom(), tip, random_mac(), now);
    req.operation = OPN_RESOLVE;
    return req;
  endfunction

  function automatic arp_in_t make_random_request(input logic [31:0] now);
    arp_in_t req;
    int      roll;
    roll = $urandom_range(99);
    req = make_packet(ARP_OP_REQUEST, random_mac(), $urandom(), $urandom(), random_mac(), now);
    if ($urandom_range(99) < 3) req.now_sec = $urandom();
    if (roll < 35) begin
      req.operation = OPN_RESOLVE;
      {req.hw_type, req.proto_type, req.hw_len, req.proto_len, req.arp_op} =
        64'({$urandom(), $urandom()});
      if ($urandom_range(99) < 15) req.target_ip = station_ip;
    end else if (roll < 50) begin
      if ($urandom_range(99) < 70) req.target_ip = station_ip;
    end else if (roll < 85) begin
      req.arp_op = ARP_OP_REPLY;
      if ($urandom_range(99) < 90) req.target_ip = station_ip;
      if ($urandom_range(99) < 85) req.sender_mac[MCAST_BIT] = 1'b0;
    end else begin
      case ($urandom_range(5))
        0: req.hw_type = 16'($urandom());
        1: req.proto_type = 16'($urandom());
        2: req.hw_len = 8'($urandom());
        3: req.proto_len = 8'($urandom());
        4: req.arp_op = 16'($urandom());
        default: begin
          {req.hw_type, req.proto_type, req.hw_len, req.proto_len, req.arp_op} =
            64'({$urandom(), $urandom()});
        end
      endcase
      if ($urandom_range(1) == 1) req.target_ip = station_ip;
    end
    return req;
  endfunction

  task automatic write_config(input logic [31:0] ip, input logic [47:0] mac,
                              input logic [15:0] life);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWN_IP;
    cfg_wdata <= {16'($urandom()), ip};
    @(posedge clk);
    station_ip = ip;
    cfg_index <= CFG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    station_mac = mac;
    cfg_index <= CFG_MAX_LIFE;
    cfg_wdata <= {32'($urandom()), life};
    @(posedge clk);
    life_limit = life;
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(input arp_in_t req);
    int gap;
    int roll;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_arp_result(req));
    roll = $urandom_range(99);
    if (no_idle || roll < 60) gap = 0;
    else if (roll < 97) gap = $urandom_range(4, 1);
    else gap = $urandom_range(60, 20);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_resolve_paths();
    write_config(32'h0A00_0001, 48'h0211_2233_4455, MAX_LIFE_RST);
    send_request(make_resolve(32'h0A00_0005, 32'd100));
    send_request(make_resolve(32'h0A00_0005, 32'd101));
    send_request(make_packet(ARP_OP_REPLY, 48'h02AA_BBCC_DD05, 32'h0A00_0005,
                             32'h0A00_0001, 48'h02AA_BBCC_DD05, 32'd100));
    send_request(make_resolve(32'h0A00_0005, 32'd160));
    send_request(make_resolve(32'h0A00_0015, 32'd150));
    send_request(make_resolve(32'h0A00_0005, 32'd161));
    send_request(make_packet(ARP_OP_REPLY, 48'h0, 32'h0A00_0009,
                             32'h0A00_0001, 48'h0, 32'd200));
    send_request(make_resolve(32'h0A00_0009, 32'd200));
  endtask

  task automatic test_packet_checks();
    arp_in_t base;
    arp_in_t req;
    base = make_packet(ARP_OP_REQUEST, 48'h0234_5678_9ABC, 32'h0A00_0077,
                       32'h0A00_0001, 48'h0A1B_2C3D_4E5F, 32'd300);
    send_request(base);
    req = base;
    req.target_ip = 32'h0A00_0002;
    send_request(req);
    send_request(make_packet(ARP_OP_REPLY, 48'h0200_0000_0006, 32'h0A00_0006,
                             32'h0A00_0002, 48'h0200_0000_0006, 32'd300));
    send_request(make_packet(ARP_OP_REPLY, 48'h0100_0000_0001, 32'h0A00_0006,
                             32'h0A00_0001, 48'h0100_0000_0001, 32'd300));
    send_request(make_packet(ARP_OP_REPLY, MAC_BCAST, 32'h0A00_0006,
                             32'h0A00_0001, MAC_BCAST, 32'd300));
    req = base;
    req.hw_type = 16'h0000;
    send_request(req);
    req = base;
    req.proto_type = 16'h86DD;
    send_request(req);
    req = base;
    req.hw_len = 8'hFF;
    send_request(req);
    req = base;
    req.proto_len = 8'h00;
    send_request(req);
    req = base;
    req.arp_op = ARP_OP_NONE;
    send_request(req);
    req = base;
    req.arp_op = 16'd3;
    send_request(req);
    req = base;
    req.arp_op = 16'hFFFF;
    send_request(req);
  endtask

  task automatic test_time_limits();
    wait_results_drained();
    write_config(32'hFFFF_FFFF, MAC_BCAST, 16'hFFFF);
    send_request(make_packet(ARP_OP_REPLY, 48'hFEFF_FFFF_FFFF, 32'h0000_00F3,
                             32'hFFFF_FFFF, MAC_BCAST, 32'hFFFF_FFFF));
    send_request(make_resolve(32'hFFFF_FF03, 32'hFFFF_FFFF));
    send_request(make_resolve(32'hFFFF_FF03, 32'h0));
    wait_results_drained();
    write_config(32'h0, 48'h0, 16'h0);
    send_request(make_packet(ARP_OP_REPLY, 48'h0000_0000_0001, 32'h0000_0004,
                             32'h0, 48'h0, 32'h0));
    send_request(make_resolve(32'h0000_0004, 32'h0));
    send_request(make_resolve(32'h0000_0004, 32'h1));
    send_request(make_packet(ARP_OP_REQUEST, 48'h0, 32'h0, 32'h0, 48'h0, 32'h0));
  endtask

  task automatic test_random_traffic();
    logic [31:0] now_val;
    int          step_max;
    int          pause_at;
    for (int phase = 0; phase < 6; phase++) begin
      wait_results_drained();
      no_idle = (phase == 3);
      case (phase)
        0: write_config($urandom(), random_mac(), MAX_LIFE_RST);
        1: write_config($urandom(), random_mac(), 16'h0);
        2: write_config($urandom(), random_mac(), 16'hFFFF);
        3: write_config(32'h0, 48'h0, 16'($urandom_range(200, 1)));
        4: write_config(32'hFFFF_FFFF, MAC_BCAST, 16'($urandom()));
        default: write_config($urandom(), random_mac(), 16'($urandom_range(600)));
      endcase
      now_val = (phase == 2) ? 32'hFFFF_FF00 : 32'($urandom());
      step_max = int'(life_limit) / 3 + 2;
      pause_at = $urandom_range(RANDOM_PER_PHASE - 10, 10);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // pause until every result is back
        if (n == pause_at) wait_results_drained();
        now_val = now_val + 32'($urandom_range(step_max));
        send_request(make_random_request(now_val));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    arp_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result expected none actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_data.kind));
        check_field("resolved_mac", 64'(want.resolved_mac), 64'(out_data.resolved_mac));
        check_field("frame_dest_mac", 64'(want.frame_dest_mac),
                    64'(out_data.frame_dest_mac));
        check_field("arp_op_out", 64'(want.arp_op_out), 64'(out_data.arp_op_out));
        check_field("target_mac_out", 64'(want.target_mac_out),
                    64'(out_data.target_mac_out));
        check_field("sender_ip_out", 64'(want.sender_ip_out), 64'(out_data.sender_ip_out));
        check_field("target_ip_out", 64'(want.target_ip_out), 64'(out_data.target_ip_out));
        check_field("release_waiting", 64'(want.release_waiting),
                    64'(out_data.release_waiting));
      end
    end
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(99);
      if (no_idle || ready_roll < 65) begin
        out_ready <= 1'b1;
      end else if (ready_roll < 97) begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(3);
      end else begin
        out_ready <= 1'b0;
        ready_hold <= $urandom_range(50, 10);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("arp_cache_and_responder: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = ST_EMPTY;
      slot_mac[i] = '0;
      slot_learned_at[i] = '0;
    end
    station_ip = '0;
    station_mac = '0;
    life_limit = MAX_LIFE_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_resolve_paths();
    test_packet_checks();
    test_time_limits();
    test_random_traffic();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("arp_cache_and_responder: match");
    end else begin
      $display("arp_cache_and_responder: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/arp_pkg.sv
rtl/arp_front.sv
rtl/arp_queue.sv
rtl/arp_back.sv
rtl/arp_cache_and_responder.sv
sim/tb.sv
